// ===== rtl/dspc_pkg.sv =====
// Types and constants shared by the dispatch event counter block.
// No dependencies; used by dspc_counters, dspc_share_div and the top level.
`default_nettype none

package dspc_pkg;

   // event commands
   localparam logic [1:0] CMD_HIT      = 2'd0;
   localparam logic [1:0] CMD_MISS     = 2'd1;
   localparam logic [1:0] CMD_FALLBACK = 2'd2;
   localparam logic [1:0] CMD_READ     = 2'd3;

   localparam int CNT_W       = 64;
   localparam int SHARE_BITS  = 20;
   localparam int SHARE_IDX_W = $clog2(SHARE_BITS);
   localparam logic [SHARE_BITS-1:0] SHARE_SCALE = 20'd1000000;

   // one dispatch event as taken from the input channel
   typedef struct packed {
      logic [1:0]  cmd;
      logic        ro_flag;
      logic [3:0]  error_code;
      logic [31:0] callsite;
      logic [31:0] target;
   } evt_type;

   // counter and first-miss capture state
   typedef struct packed {
      logic [CNT_W-1:0] hits;
      logic [CNT_W-1:0] misses;
      logic [CNT_W-1:0] fallbacks;
      logic [CNT_W-1:0] ro_hits;
      logic [CNT_W-1:0] ro_misses;
      logic [CNT_W-1:0] ro_fallbacks;
      logic             cap_valid;
      logic [3:0]       cap_error;
      logic             cap_class;
      logic [31:0]      cap_callsite;
      logic [31:0]      cap_target;
   } cnt_type;

endpackage

`default_nettype wire

// ===== rtl/dspc_counters.sv =====
// Six saturating event counters and the first-miss capture registers.
// Depends on dspc_pkg for the event and counter types.
`default_nettype none

module dspc_counters (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             evt_valid,
   input  wire dspc_pkg::evt_type evt,
   output dspc_pkg::cnt_type     cnt
);

   dspc_pkg::cnt_type cnt_ff;
   dspc_pkg::cnt_type cnt_in;

   // saturating increment
   function automatic logic [dspc_pkg::CNT_W-1:0] sat_inc(
      input logic [dspc_pkg::CNT_W-1:0] v);
      sat_inc = (&v) ? v : v + dspc_pkg::CNT_W'(1);
   endfunction

   // next counter and capture state
   always_comb begin
      cnt_in = cnt_ff;
      if (evt_valid) begin
         case (evt.cmd)
            dspc_pkg::CMD_HIT: begin
               cnt_in.hits = sat_inc(cnt_ff.hits);
               if (evt.ro_flag) cnt_in.ro_hits = sat_inc(cnt_ff.ro_hits);
            end
            dspc_pkg::CMD_MISS: begin
               cnt_in.misses = sat_inc(cnt_ff.misses);
               if (evt.ro_flag) cnt_in.ro_misses = sat_inc(cnt_ff.ro_misses);
               if (!cnt_ff.cap_valid) begin
                  cnt_in.cap_valid    = 1'b1;
                  cnt_in.cap_error    = evt.error_code;
                  cnt_in.cap_class    = evt.ro_flag;
                  cnt_in.cap_callsite = evt.callsite;
                  cnt_in.cap_target   = evt.target;
               end
            end
            dspc_pkg::CMD_FALLBACK: begin
               cnt_in.fallbacks = sat_inc(cnt_ff.fallbacks);
               if (evt.ro_flag) begin
                  cnt_in.ro_fallbacks = sat_inc(cnt_ff.ro_fallbacks);
               end
            end
            dspc_pkg::CMD_READ: begin
               cnt_in = cnt_ff;
            end
            default: begin
               cnt_in = cnt_ff;
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign cnt = cnt_ff;

   // once captured, the capture never changes
   a_cap_sticky: assert property (@(posedge clock) disable iff (reset)
      cnt_ff.cap_valid |=> cnt_ff.cap_valid && $stable(cnt_ff.cap_callsite)
                           && $stable(cnt_ff.cap_target))
      else $error("first-miss capture changed after being set");

   // runtime-only counts never exceed the totals
   a_ro_le_total: assert property (@(posedge clock) disable iff (reset)
      cnt_ff.ro_hits <= cnt_ff.hits && cnt_ff.ro_misses <= cnt_ff.misses
      && cnt_ff.ro_fallbacks <= cnt_ff.fallbacks)
      else $error("runtime-only count above total");

   // capture is set by a miss only
   a_cap_by_miss: assert property (@(posedge clock) disable iff (reset)
      $rose(cnt_ff.cap_valid) |-> $past(evt_valid)
                                  && $past(evt.cmd) == dspc_pkg::CMD_MISS)
      else $error("capture set without a miss");

endmodule

`default_nettype wire

// ===== rtl/dspc_share_div.sv =====
// Bit-serial share unit: floor(n * 1e6 / d) over saturated counter sums (zero
// when d is zero), one quotient step per cycle. Depends on dspc_pkg.
`default_nettype none

module dspc_share_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic                        ack,
   input  wire dspc_pkg::cnt_type           cnt,
   output logic                             done,
   output logic [dspc_pkg::SHARE_BITS-1:0]  share
);

   localparam int W  = dspc_pkg::CNT_W;
   localparam int QW = dspc_pkg::SHARE_BITS;
   localparam int KW = dspc_pkg::SHARE_IDX_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SUM   = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_ITER  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [W-1:0]  n_ff, n_in;
   logic [W-1:0]  d_ff, d_in;
   logic [W-1:0]  r_ff, r_in;
   logic [QW-1:0] q_ff, q_in;
   logic [KW-1:0] k_ff, k_in;

   logic [W:0]    n_sum;
   logic [W:0]    d_sum;
   logic          scale_bit;
   logic [W+1:0]  s_w;
   logic [W+1:0]  d1_w;
   logic [W+1:0]  d2_w;
   logic          ge1;
   logic          ge2;
   logic [W+1:0]  r_w;
   logic [QW-1:0] q_step;

   // saturating sums of the counters
   assign n_sum = {1'b0, cnt.ro_hits} + {1'b0, cnt.ro_misses};
   assign d_sum = {1'b0, cnt.hits} + {1'b0, cnt.misses};

   // one recurrence step: r = 2r + bit*n, then reduce by d or 2d
   assign scale_bit = dspc_pkg::SHARE_SCALE[k_ff];
   assign s_w  = {1'b0, r_ff, 1'b0} + {2'b00, (scale_bit ? n_ff : {W{1'b0}})};
   assign d1_w = {2'b00, d_ff};
   assign d2_w = {1'b0, d_ff, 1'b0};
   assign ge2  = s_w >= d2_w;
   assign ge1  = s_w >= d1_w;
   assign r_w  = ge2 ? s_w - d2_w : (ge1 ? s_w - d1_w : s_w);
   assign q_step = {q_ff[QW-2:0], 1'b0}
                 + (ge2 ? QW'(2) : (ge1 ? QW'(1) : QW'(0)));

   // sequencer
   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      d_in     = d_ff;
      r_in     = r_ff;
      q_in     = q_ff;
      k_in     = k_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_SUM;
         end
         ST_SUM: begin
            n_in     = n_sum[W] ? '1 : n_sum[W-1:0];
            d_in     = d_sum[W] ? '1 : d_sum[W-1:0];
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            r_in = '0;
            k_in = KW'(QW - 1);
            if (d_ff == '0) begin
               q_in     = '0;
               state_in = ST_DONE;
            end else if (n_ff >= d_ff) begin
               q_in     = dspc_pkg::SHARE_SCALE;
               state_in = ST_DONE;
            end else begin
               q_in     = '0;
               state_in = ST_ITER;
            end
         end
         ST_ITER: begin
            r_in = r_w[W-1:0];
            q_in = q_step;
            k_in = k_ff - KW'(1);
            if (k_ff == '0) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (ack) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      n_ff <= n_in;
      d_ff <= d_in;
      r_ff <= r_in;
      q_ff <= q_in;
      k_ff <= k_in;
   end

   assign done  = state_ff == ST_DONE;
   assign share = q_ff;

   // the remainder and numerator stay below the divisor while iterating
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ITER |-> r_ff < d_ff && n_ff < d_ff)
      else $error("share remainder out of range");

   // the result never exceeds the scale
   a_share_max: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> q_ff <= dspc_pkg::SHARE_SCALE)
      else $error("share above scale");

   // a new run starts only when the unit is free
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == ST_IDLE)
      else $error("share unit started while busy");

endmodule

`default_nettype wire

// ===== rtl/dispatch_event_counters_with_share.sv =====
// Top level of the dispatch event counter block with runtime-only share.
// Depends on dspc_pkg, dspc_counters and dspc_share_div.
`default_nettype none

// One event is taken per item and one result returned per item. The
// counters update at the input transfer; the share unit then forms the
// saturated sums, makes the zero and full-share checks and, unless a check
// settles the result, works out the runtime-only share one quotient bit
// per cycle. The input is held off while the share unit runs; a
// finished result sits in the output register while the next event is
// already being counted.
module dispatch_event_counters_with_share (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // error_code[3:0], callsite[35:4], target[67:36], zero fill
   input  wire logic [71:0]  req_tdata,
   // cmd[1:0], ro_flag[2]
   input  wire logic [2:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // hit_count[63:0], miss_count[127:64], fallback_count[191:128],
   // ro_hit_count[255:192], ro_miss_count[319:256], ro_fallback_count[383:320],
   // share_ppm[403:384], first_valid[404], first_err_code[408:405],
   // first_ro_class[409], first_callsite[441:410], first_target[473:442],
   // zero fill
   output logic [479:0]      rsp_tdata
);

   dspc_pkg::evt_type evt;
   dspc_pkg::cnt_type cnt;
   logic              req_xfer;
   logic              div_done;
   logic              load;
   logic [dspc_pkg::SHARE_BITS-1:0] share;

   logic              busy_ff, busy_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [479:0]      rsp_data_ff, rsp_data_in;

   // unpack the input transfer
   assign evt.cmd          = req_tuser[1:0];
   assign evt.ro_flag      = req_tuser[2];
   assign evt.error_code   = req_tdata[3:0];
   assign evt.callsite     = req_tdata[35:4];
   assign evt.target       = req_tdata[67:36];

   assign req_tready = !busy_ff;
   assign req_xfer   = req_tvalid && req_tready;

   dspc_counters u_counters (
      .clock     (clock),
      .reset     (reset),
      .evt_valid (req_xfer),
      .evt       (evt),
      .cnt       (cnt)
   );

   dspc_share_div u_share_div (
      .clock (clock),
      .reset (reset),
      .start (req_xfer),
      .ack   (load),
      .cnt   (cnt),
      .done  (div_done),
      .share (share)
   );

   // result moves to the output register once it is free
   assign load = div_done && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (req_xfer) busy_in = 1'b1;
      if (load) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0, cnt.cap_target, cnt.cap_callsite, cnt.cap_class,
                         cnt.cap_error, cnt.cap_valid, share,
                         cnt.ro_fallbacks, cnt.ro_misses, cnt.ro_hits,
                         cnt.fallbacks, cnt.misses, cnt.hits};
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // one event in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready)
      else $error("input taken while share unit busy");

   // a loaded result is shown on the next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_tvalid)
      else $error("loaded result not presented");

   // the share unit only finishes for an accepted event
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      div_done |-> busy_ff)
      else $error("share result without an event");

endmodule

`default_nettype wire
